// ===== rtl/core/cke_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cke_pkg;

   localparam int KEY_REGS            = 4;
   localparam int CSR_INDEX_W         = 2;
   localparam int NUM_ROUNDS          = 20;
   localparam int ROUND_W             = 5;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [3:0][31:0] SIGMA_WORDS = {
      32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
   };

   typedef logic [15:0][31:0]        word_block_type;
   typedef logic [3:0][31:0]         word_quad_type;
   typedef logic [KEY_REGS-1:0][63:0] key_type;

   // One request as handed from the front to the back.
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic        new_block;
      logic [5:0]  position;
      logic [63:0] counter;
      logic [31:0] nonce;
   } entry_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      rotl = (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] byte_swap(input logic [31:0] x);
      byte_swap = {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   function automatic word_quad_type quarter_round(input word_quad_type q);
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      a = q[0];
      b = q[1];
      c = q[2];
      d = q[3];
      a = a + b; d = rotl(d ^ a, 16);
      c = c + d; b = rotl(b ^ c, 12);
      a = a + b; d = rotl(d ^ a, 8);
      c = c + d; b = rotl(b ^ c, 7);
      quarter_round = {d, c, b, a};
   endfunction

   // Four independent quarter rounds: columns, or diagonals when diag is set.
   function automatic word_block_type half_round(input word_block_type w, input logic diag);
      word_block_type res;
      word_quad_type  q;
      int             ia;
      int             ib;
      int             ic;
      int             id;
      res = w;
      for (int i = 0; i < 4; i++) begin
         ia = i;
         ib = diag ? 4 + ((i + 1) & 3) : 4 + i;
         ic = diag ? 8 + ((i + 2) & 3) : 8 + i;
         id = diag ? 12 + ((i + 3) & 3) : 12 + i;
         q = quarter_round({w[id], w[ic], w[ib], w[ia]});
         res[ia] = q[0];
         res[ib] = q[1];
         res[ic] = q[2];
         res[id] = q[3];
      end
      half_round = res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cke_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cke_front import cke_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [63:0] req_start_counter,
   input  wire logic [31:0] req_sequence_number,
   input  wire logic        req_last_byte,
   output logic             push_valid,
   output entry_type        push_entry,
   input  wire logic        queue_full
);

   logic        in_message_ff, in_message_in;
   logic [5:0]  position_ff, position_in;
   logic [63:0] counter_ff, counter_in;
   logic [31:0] nonce_ff, nonce_in;

   logic        accept;
   logic        first;
   logic [5:0]  cur_position;
   logic [63:0] cur_counter;
   logic [31:0] cur_nonce;
   logic        new_block;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign push_valid = accept;

   // The first byte of a message latches the counter and nonce.
   assign first        = !in_message_ff;
   assign cur_position = first ? 6'd0 : position_ff;
   assign cur_counter  = first ? req_start_counter : counter_ff;
   assign cur_nonce    = first ? byte_swap(req_sequence_number) : nonce_ff;
   assign new_block    = (cur_position == 6'd0);

   always_comb begin
      push_entry.data_byte = req_data_byte;
      push_entry.last_byte = req_last_byte;
      push_entry.new_block = new_block;
      push_entry.position  = cur_position;
      push_entry.counter   = cur_counter;
      push_entry.nonce     = cur_nonce;
   end

   always_comb begin
      in_message_in = in_message_ff;
      position_in   = position_ff;
      counter_in    = counter_ff;
      nonce_in      = nonce_ff;
      if (accept) begin
         in_message_in = !req_last_byte;
         position_in   = 6'(cur_position + 6'd1);
         counter_in    = new_block ? 64'(cur_counter + 64'd1) : cur_counter;
         nonce_in      = cur_nonce;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_message_ff <= 1'b0;
         position_ff   <= '0;
         counter_ff    <= '0;
         nonce_ff      <= '0;
      end else begin
         in_message_ff <= in_message_in;
         position_ff   <= position_in;
         counter_ff    <= counter_in;
         nonce_ff      <= nonce_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cke_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cke_fifo import cke_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   input  wire entry_type push_entry,
   output logic           full,
   output logic           head_valid,
   output entry_type      head_entry,
   input  wire logic      pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/cke_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cke_back import cke_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire key_type   key_words,
   input  wire logic      head_valid,
   input  wire entry_type head_entry,
   output logic           pop,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output logic [7:0]     rsp_result_byte,
   output logic           rsp_result_last
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_FINAL = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         result_byte_ff, result_byte_in;
   logic               result_last_ff, result_last_in;
   word_block_type     init_ff, init_in;
   word_block_type     work_ff, work_in;
   word_block_type     stream_ff, stream_in;

   word_block_type     init_words;
   logic               out_free;
   logic               emit;
   logic [31:0]        stream_word;
   logic [31:0]        stream_shifted;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         init_words[i]         = SIGMA_WORDS[i];
         init_words[4 + 2 * i] = key_words[i][31:0];
         init_words[5 + 2 * i] = key_words[i][63:32];
      end
      init_words[12] = head_entry.counter[31:0];
      init_words[13] = head_entry.counter[63:32];
      init_words[14] = '0;
      init_words[15] = head_entry.nonce;
   end

   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign stream_word    = stream_ff[head_entry.position[5:2]];
   assign stream_shifted = stream_word >> {head_entry.position[1:0], 3'b000};

   always_comb begin
      state_in  = state_ff;
      round_in  = round_ff;
      init_in   = init_ff;
      work_in   = work_ff;
      stream_in = stream_ff;
      emit      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               if (head_entry.new_block) begin
                  init_in  = init_words;
                  work_in  = init_words;
                  round_in = '0;
                  state_in = ST_ROUND;
               end else if (out_free) begin
                  emit = 1'b1;
               end
            end
         end
         ST_ROUND: begin
            // even steps mix columns, odd steps mix diagonals
            work_in  = half_round(work_ff, round_ff[0]);
            round_in = ROUND_W'(round_ff + 1'b1);
            if (round_ff == ROUND_W'(NUM_ROUNDS - 1)) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            for (int i = 0; i < 16; i++) begin
               stream_in[i] = work_ff[i] + init_ff[i];
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign pop = emit;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      result_byte_in = result_byte_ff;
      result_last_in = result_last_ff;
      if (emit) begin
         rsp_valid_in   = 1'b1;
         result_byte_in = head_entry.data_byte ^ stream_shifted[7:0];
         result_last_in = head_entry.last_byte;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      init_ff        <= init_in;
      work_ff        <= work_in;
      stream_ff      <= stream_in;
      result_byte_ff <= result_byte_in;
      result_last_ff <= result_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_byte = result_byte_ff;
   assign rsp_result_last = result_last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/chacha20_keystream_xor.sv =====
// ChaCha20 keystream XOR, 64-bit block counter and 64-bit nonce.
// Requests carry one message byte each on req_* (valid/stall). The first
// byte of a message latches req_start_counter and req_sequence_number; the
// nonce is zero in its low word and the byte-swapped sequence number above.
// req_last_byte ends the message and is returned on rsp_result_last.
// Results leave on rsp_* (valid/stall) as the byte XOR the keystream.
// The 256-bit key is written through csr_* in four 64-bit words
// (index 0 holds key bytes 0..7); csr_ready is always high.
// A byte inside a block passes through the queue and the result register
// to rsp_valid. At byte 0 of every 64-byte block the back end runs 20
// rounds, one column or diagonal round per cycle, then the final add,
// before that byte is emitted. The round engine sets the throughput;
// the two-entry queue holds one more byte while a block is being made.
// Reset clears the key, the message state and rsp_valid, not the result byte.
// A stalled result holds rsp_* and, once the queue fills, stalls req_*.
`timescale 1ns / 1ps
`default_nettype none

module chacha20_keystream_xor import cke_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_data_byte,
   input  wire logic [63:0]            req_start_counter,
   input  wire logic [31:0]            req_sequence_number,
   input  wire logic                   req_last_byte,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_result_byte,
   output logic                        rsp_result_last,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [63:0]            csr_wdata
);

   key_type   key_ff, key_in;
   logic      push_valid;
   entry_type push_entry;
   logic      queue_full;
   logic      head_valid;
   entry_type head_entry;
   logic      pop;

   assign csr_ready = 1'b1;

   always_comb begin
      key_in = key_ff;
      if (csr_valid && csr_ready) begin
         key_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   cke_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_start_counter   (req_start_counter),
      .req_sequence_number (req_sequence_number),
      .req_last_byte       (req_last_byte),
      .push_valid          (push_valid),
      .push_entry          (push_entry),
      .queue_full          (queue_full)
   );

   cke_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   cke_back u_back (
      .clock           (clock),
      .reset           (reset),
      .key_words       (key_ff),
      .head_valid      (head_valid),
      .head_entry      (head_entry),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_byte (rsp_result_byte),
      .rsp_result_last (rsp_result_last)
   );

endmodule

`default_nettype wire
